// ----- rtl/salb_pkg.sv -----
// ----------------------------------------------------------------------------
// salb_pkg
// Shared types, codes and defaults of the suffix array / LCP builder.
// ----------------------------------------------------------------------------
`default_nettype none

package salb_pkg;

  localparam int MAX_LEN_DEFAULT  = 4095;
  localparam int ALPHABET_DEFAULT = 256;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } salb_op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NOT_BUILT = 2'd3
  } salb_status_t;

  typedef enum logic [5:0] {
    S_IDLE,
    S_RD_A,
    S_RD_D,
    S_B_SENT,
    S_B_INIT_RD,
    S_B_INIT_WR,
    S_P_START,
    S_P_YA,
    S_P_YB_RD,
    S_P_YB_CHK,
    S_P_CLR,
    S_P_CNT_RD,
    S_P_CNT_B,
    S_P_CNT_W,
    S_P_SUM_START,
    S_P_SUM_INIT,
    S_P_SUM_RD,
    S_P_SUM_W,
    S_P_SC_RD,
    S_P_SC_X,
    S_P_SC_B,
    S_P_SC_W,
    S_P_RR_START,
    S_P_RR_SA,
    S_P_RR_Y0,
    S_P_RR_Y1,
    S_P_RR_Y2,
    S_P_RR_WR,
    S_P_END,
    S_K_RD,
    S_K_R,
    S_K_O,
    S_K_CMP_A,
    S_K_CMP_B,
    S_K_CMP_C,
    S_K_WR,
    S_DONE
  } salb_state_t;

endpackage

`default_nettype wire

// ----- rtl/salb_ram.sv -----
// ----------------------------------------------------------------------------
// salb_ram
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module salb_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 12
) (
  input  wire logic                     clk,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic                     we,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ----- rtl/suffix_array_lcp_builder_top.sv -----
// ----------------------------------------------------------------------------
// suffix_array_lcp_builder_top
// Loads a text, builds its suffix array by prefix doubling and its LCP array
// by Kasai's method, and answers rank reads.
// ----------------------------------------------------------------------------
// A load item stores one symbol. A read passes through the address state, the
// registered memory data and the result into the output register, and waits at
// the data state while an earlier result is not taken. A build stalls the input
// for its whole run, set by single-port memory sequencing: it copies the text,
// then each doubling pass builds the suffix list, clears the buckets, counts,
// forms the prefix sum, scatters and re-ranks, and the Kasai pass ends the build.
// There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module suffix_array_lcp_builder_top #(
  parameter int MAX_LEN  = salb_pkg::MAX_LEN_DEFAULT,
  parameter int ALPHABET = salb_pkg::ALPHABET_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // op[1:0], symbol[9:2], rank_index[21:10]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // status[1:0], suffix_start[13:2],
                                       // common_prefix[25:14], text_length[38:26]
);

  localparam int STORE  = MAX_LEN + 1;
  localparam int BDEPTH = (STORE > ALPHABET) ? STORE : ALPHABET;
  localparam int AW     = $clog2(STORE);     // text position
  localparam int BW     = $clog2(BDEPTH);    // rank value / bucket index
  localparam int IW     = $clog2(BDEPTH + 1); // counts, lengths

  // Input fields
  logic [1:0]  in_op;
  logic [7:0]  in_symbol;
  logic [11:0] in_rank_index;
  assign in_op         = in_tdata[1:0];
  assign in_symbol     = in_tdata[9:2];
  assign in_rank_index = in_tdata[21:10];

  salb_pkg::salb_state_t state_r, state_nxt;

  logic [IW-1:0] i_r, i_nxt, n_r, n_nxt, j_r, j_nxt, p_r, p_nxt;
  logic [IW-1:0] lim_r, lim_nxt, acc_r, acc_nxt, k_r, k_nxt;
  logic [IW-1:0] loaded_r, loaded_nxt, blen_r, blen_nxt;
  logic          sel_r, sel_nxt, ovf_r, ovf_nxt, built_r, built_nxt;
  logic [BW-1:0] c_r, c_nxt, cur_y0_r, cur_y0_nxt, cur_y1_r, cur_y1_nxt;
  logic [BW-1:0] prev_y0_r, prev_y0_nxt, prev_y1_r, prev_y1_nxt;
  logic          cur_in_r, cur_in_nxt, prev_in_r, prev_in_nxt;
  logic [AW-1:0] yi_r, yi_nxt, cur_b_r, cur_b_nxt, r_r, r_nxt, o_r, o_nxt;
  logic [7:0]    t_r, t_nxt;
  logic [11:0]   rank_r, rank_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [39:0]   out_data_r, out_data_nxt;

  // Memory ports
  logic [AW-1:0] txt_addr, sa_addr, lcp_addr, x_addr, y_addr;
  logic [BW-1:0] bkt_addr;
  logic          txt_we, sa_we, lcp_we, x_we, y_we, bkt_we;
  logic [7:0]    txt_wd, txt_rd;
  logic [AW-1:0] sa_wd, sa_rd, lcp_wd, lcp_rd;
  logic [BW-1:0] x_wd, y_wd, x_rd, y_rd, rk0_rd, rk1_rd;
  logic [IW-1:0] bkt_wd, bkt_rd;

  salb_ram #(.DEPTH(STORE), .WIDTH(8)) u_txt (
    .clk(clk), .addr(txt_addr), .we(txt_we), .wdata(txt_wd), .rdata(txt_rd));
  salb_ram #(.DEPTH(STORE), .WIDTH(AW)) u_sa (
    .clk(clk), .addr(sa_addr), .we(sa_we), .wdata(sa_wd), .rdata(sa_rd));
  salb_ram #(.DEPTH(STORE), .WIDTH(AW)) u_lcp (
    .clk(clk), .addr(lcp_addr), .we(lcp_we), .wdata(lcp_wd), .rdata(lcp_rd));
  salb_ram #(.DEPTH(BDEPTH), .WIDTH(IW)) u_bkt (
    .clk(clk), .addr(bkt_addr), .we(bkt_we), .wdata(bkt_wd), .rdata(bkt_rd));

  // Two rank memories swap roles (current rank x, scratch y) every pass.
  salb_ram #(.DEPTH(STORE), .WIDTH(BW)) u_rk0 (
    .clk(clk), .addr(sel_r ? y_addr : x_addr), .we(sel_r ? y_we : x_we),
    .wdata(sel_r ? y_wd : x_wd), .rdata(rk0_rd));
  salb_ram #(.DEPTH(STORE), .WIDTH(BW)) u_rk1 (
    .clk(clk), .addr(sel_r ? x_addr : y_addr), .we(sel_r ? x_we : y_we),
    .wdata(sel_r ? x_wd : y_wd), .rdata(rk1_rd));

  assign x_rd = sel_r ? rk1_rd : rk0_rd;
  assign y_rd = sel_r ? rk0_rd : rk1_rd;

  assign in_tready  = (state_r == salb_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  logic          sym_ok, same;
  logic [IW:0]   sum_a, sum_b;
  logic [IW-1:0] acc_sum, bkt_dec, k_dec;

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    n_nxt         = n_r;
    j_nxt         = j_r;
    p_nxt         = p_r;
    lim_nxt       = lim_r;
    acc_nxt       = acc_r;
    k_nxt         = k_r;
    loaded_nxt    = loaded_r;
    blen_nxt      = blen_r;
    sel_nxt       = sel_r;
    ovf_nxt       = ovf_r;
    built_nxt     = built_r;
    c_nxt         = c_r;
    cur_y0_nxt    = cur_y0_r;
    cur_y1_nxt    = cur_y1_r;
    prev_y0_nxt   = prev_y0_r;
    prev_y1_nxt   = prev_y1_r;
    cur_in_nxt    = cur_in_r;
    prev_in_nxt   = prev_in_r;
    yi_nxt        = yi_r;
    cur_b_nxt     = cur_b_r;
    r_nxt         = r_r;
    o_nxt         = o_r;
    t_nxt         = t_r;
    rank_nxt      = rank_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    txt_addr = '0; txt_we = 1'b0; txt_wd = '0;
    sa_addr  = '0; sa_we  = 1'b0; sa_wd  = '0;
    lcp_addr = '0; lcp_we = 1'b0; lcp_wd = '0;
    bkt_addr = '0; bkt_we = 1'b0; bkt_wd = '0;
    x_addr   = '0; x_we   = 1'b0; x_wd   = '0;
    y_addr   = '0; y_we   = 1'b0; y_wd   = '0;

    sym_ok  = (in_symbol != 8'd0) && (32'(in_symbol) < ALPHABET);
    sum_a   = '0;
    sum_b   = '0;
    acc_sum = acc_r + bkt_rd;
    bkt_dec = bkt_rd - IW'(1);
    k_dec   = (k_r != '0) ? (k_r - IW'(1)) : k_r;
    same    = (prev_y0_r == cur_y0_r) && prev_in_r && cur_in_r &&
              (prev_y1_r == cur_y1_r);

    // Drop the result once taken.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      salb_pkg::S_IDLE: begin
        if (in_tvalid) begin
          case (salb_pkg::salb_op_t'(in_op))
            salb_pkg::OP_LOAD: begin
              if (sym_ok) begin
                if (32'(loaded_r) >= MAX_LEN) begin
                  ovf_nxt = 1'b1;
                end else begin
                  txt_addr   = AW'(loaded_r);
                  txt_we     = 1'b1;
                  txt_wd     = in_symbol;
                  loaded_nxt = loaded_r + IW'(1);
                  built_nxt  = 1'b0;
                end
              end
            end
            salb_pkg::OP_BUILD: state_nxt = salb_pkg::S_B_SENT;
            salb_pkg::OP_READ: begin
              rank_nxt  = in_rank_index;
              state_nxt = salb_pkg::S_RD_A;
            end
            salb_pkg::OP_CLEAR: begin
              loaded_nxt = '0;
              ovf_nxt    = 1'b0;
              built_nxt  = 1'b0;
              blen_nxt   = '0;
            end
            default: ;
          endcase
        end
      end

      salb_pkg::S_RD_A: begin
        sa_addr   = AW'(rank_r);
        lcp_addr  = AW'(rank_r);
        state_nxt = salb_pkg::S_RD_D;
      end

      salb_pkg::S_RD_D: begin
        // Hold the address so the read data stays while the output is full.
        sa_addr  = AW'(rank_r);
        lcp_addr = AW'(rank_r);
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = salb_pkg::S_IDLE;
          if (!built_r) begin
            out_data_nxt = {1'b0, 13'd0, 12'd0, 12'd0, salb_pkg::ST_NOT_BUILT};
          end else if (32'(rank_r) >= 32'(blen_r)) begin
            out_data_nxt = {1'b0, 13'(blen_r), 12'd0, 12'd0, salb_pkg::ST_RANGE};
          end else begin
            out_data_nxt = {1'b0, 13'(blen_r),
                            (rank_r == 12'd0) ? 12'd0 : 12'(lcp_rd),
                            12'(sa_rd),
                            ovf_r ? salb_pkg::ST_OVERFLOW : salb_pkg::ST_OK};
          end
        end
      end

      // ---- build: append sentinel, copy text into ranks, identity order
      salb_pkg::S_B_SENT: begin
        txt_addr  = AW'(loaded_r);
        txt_we    = 1'b1;
        txt_wd    = 8'd0;
        n_nxt     = loaded_r + IW'(1);
        i_nxt     = '0;
        j_nxt     = '0;
        sel_nxt   = 1'b0;
        lim_nxt   = IW'(ALPHABET);
        state_nxt = salb_pkg::S_B_INIT_RD;
      end

      salb_pkg::S_B_INIT_RD: begin
        txt_addr  = AW'(i_r);
        state_nxt = salb_pkg::S_B_INIT_WR;
      end

      salb_pkg::S_B_INIT_WR: begin
        x_addr = AW'(i_r);
        x_we   = 1'b1;
        x_wd   = BW'(txt_rd);
        sa_addr = AW'(i_r);
        sa_we   = 1'b1;
        sa_wd   = AW'(i_r);
        i_nxt   = i_r + IW'(1);
        state_nxt = (i_r + IW'(1) == n_r) ? salb_pkg::S_P_START :
                                            salb_pkg::S_B_INIT_RD;
      end

      // ---- doubling pass: order by second key
      salb_pkg::S_P_START: begin
        p_nxt     = '0;
        i_nxt     = '0;
        state_nxt = salb_pkg::S_P_YA;
      end

      salb_pkg::S_P_YA: begin
        if (i_r < j_r && i_r < n_r) begin
          y_addr = AW'(p_r);
          y_we   = 1'b1;
          y_wd   = BW'(n_r - j_r + i_r);
          p_nxt  = p_r + IW'(1);
          i_nxt  = i_r + IW'(1);
        end else begin
          i_nxt     = '0;
          state_nxt = salb_pkg::S_P_YB_RD;
        end
      end

      salb_pkg::S_P_YB_RD: begin
        if (i_r < n_r) begin
          sa_addr   = AW'(i_r);
          state_nxt = salb_pkg::S_P_YB_CHK;
        end else begin
          i_nxt     = '0;
          state_nxt = salb_pkg::S_P_CLR;
        end
      end

      salb_pkg::S_P_YB_CHK: begin
        if (IW'(sa_rd) >= j_r && p_r < n_r) begin
          y_addr = AW'(p_r);
          y_we   = 1'b1;
          y_wd   = BW'(IW'(sa_rd) - j_r);
          p_nxt  = p_r + IW'(1);
        end
        i_nxt     = i_r + IW'(1);
        state_nxt = salb_pkg::S_P_YB_RD;
      end

      // ---- counting sort on the first key
      salb_pkg::S_P_CLR: begin
        bkt_addr = BW'(i_r);
        bkt_we   = 1'b1;
        bkt_wd   = '0;
        if (i_r + IW'(1) == lim_r) begin
          i_nxt     = '0;
          state_nxt = salb_pkg::S_P_CNT_RD;
        end else begin
          i_nxt = i_r + IW'(1);
        end
      end

      salb_pkg::S_P_CNT_RD: begin
        x_addr    = AW'(i_r);
        state_nxt = salb_pkg::S_P_CNT_B;
      end

      salb_pkg::S_P_CNT_B: begin
        bkt_addr  = x_rd;
        c_nxt     = x_rd;
        state_nxt = salb_pkg::S_P_CNT_W;
      end

      salb_pkg::S_P_CNT_W: begin
        bkt_addr  = c_r;
        bkt_we    = 1'b1;
        bkt_wd    = bkt_rd + IW'(1);
        i_nxt     = i_r + IW'(1);
        state_nxt = (i_r + IW'(1) == n_r) ? salb_pkg::S_P_SUM_START :
                                            salb_pkg::S_P_CNT_RD;
      end

      salb_pkg::S_P_SUM_START: begin
        bkt_addr  = '0;
        state_nxt = salb_pkg::S_P_SUM_INIT;
      end

      salb_pkg::S_P_SUM_INIT: begin
        acc_nxt   = bkt_rd;
        i_nxt     = IW'(1);
        state_nxt = salb_pkg::S_P_SUM_RD;
      end

      salb_pkg::S_P_SUM_RD: begin
        if (i_r < lim_r) begin
          bkt_addr  = BW'(i_r);
          state_nxt = salb_pkg::S_P_SUM_W;
        end else begin
          i_nxt     = n_r - IW'(1);
          state_nxt = salb_pkg::S_P_SC_RD;
        end
      end

      salb_pkg::S_P_SUM_W: begin
        bkt_addr  = BW'(i_r);
        bkt_we    = 1'b1;
        bkt_wd    = acc_sum;
        acc_nxt   = acc_sum;
        i_nxt     = i_r + IW'(1);
        state_nxt = salb_pkg::S_P_SUM_RD;
      end

      salb_pkg::S_P_SC_RD: begin
        y_addr    = AW'(i_r);
        state_nxt = salb_pkg::S_P_SC_X;
      end

      salb_pkg::S_P_SC_X: begin
        yi_nxt    = AW'(y_rd);
        x_addr    = AW'(y_rd);
        state_nxt = salb_pkg::S_P_SC_B;
      end

      salb_pkg::S_P_SC_B: begin
        c_nxt     = x_rd;
        bkt_addr  = x_rd;
        state_nxt = salb_pkg::S_P_SC_W;
      end

      salb_pkg::S_P_SC_W: begin
        bkt_addr = c_r;
        bkt_we   = 1'b1;
        bkt_wd   = bkt_dec;
        sa_addr  = AW'(bkt_dec);
        sa_we    = 1'b1;
        sa_wd    = yi_r;
        if (i_r == '0) begin
          state_nxt = salb_pkg::S_P_RR_START;
        end else begin
          i_nxt     = i_r - IW'(1);
          state_nxt = salb_pkg::S_P_SC_RD;
        end
      end

      // ---- re-rank: old ranks become scratch, new ranks go to the other memory
      salb_pkg::S_P_RR_START: begin
        sel_nxt   = ~sel_r;
        i_nxt     = '0;
        state_nxt = salb_pkg::S_P_RR_SA;
      end

      salb_pkg::S_P_RR_SA: begin
        sa_addr   = AW'(i_r);
        state_nxt = salb_pkg::S_P_RR_Y0;
      end

      salb_pkg::S_P_RR_Y0: begin
        cur_b_nxt = sa_rd;
        y_addr    = sa_rd;
        state_nxt = salb_pkg::S_P_RR_Y1;
      end

      salb_pkg::S_P_RR_Y1: begin
        cur_y0_nxt = y_rd;
        sum_a      = (IW + 1)'(cur_b_r) + (IW + 1)'(j_r);
        cur_in_nxt = sum_a < (IW + 1)'(n_r);
        cur_y1_nxt = '0;
        if (sum_a < (IW + 1)'(n_r)) begin
          y_addr    = AW'(sum_a);
          state_nxt = salb_pkg::S_P_RR_Y2;
        end else begin
          state_nxt = salb_pkg::S_P_RR_WR;
        end
      end

      salb_pkg::S_P_RR_Y2: begin
        cur_y1_nxt = y_rd;
        state_nxt  = salb_pkg::S_P_RR_WR;
      end

      salb_pkg::S_P_RR_WR: begin
        x_addr = cur_b_r;
        x_we   = 1'b1;
        if (i_r == '0) begin
          x_wd  = '0;
          p_nxt = IW'(1);
        end else if (same) begin
          x_wd = BW'(p_r - IW'(1));
        end else begin
          x_wd  = BW'(p_r);
          p_nxt = p_r + IW'(1);
        end
        prev_y0_nxt = cur_y0_r;
        prev_y1_nxt = cur_y1_r;
        prev_in_nxt = cur_in_r;
        i_nxt       = i_r + IW'(1);
        state_nxt   = (i_r + IW'(1) == n_r) ? salb_pkg::S_P_END :
                                              salb_pkg::S_P_RR_SA;
      end

      salb_pkg::S_P_END: begin
        lim_nxt = p_r;
        j_nxt   = (j_r == '0) ? IW'(1) : (j_r << 1);
        if (p_r < n_r) begin
          state_nxt = salb_pkg::S_P_START;
        end else begin
          i_nxt     = '0;
          k_nxt     = '0;
          state_nxt = salb_pkg::S_K_RD;
        end
      end

      // ---- Kasai LCP
      salb_pkg::S_K_RD: begin
        if (i_r + IW'(1) < n_r) begin
          x_addr    = AW'(i_r);
          state_nxt = salb_pkg::S_K_R;
        end else begin
          state_nxt = salb_pkg::S_DONE;
        end
      end

      salb_pkg::S_K_R: begin
        if (x_rd == '0) begin
          k_nxt     = '0;
          i_nxt     = i_r + IW'(1);
          state_nxt = salb_pkg::S_K_RD;
        end else begin
          k_nxt     = k_dec;
          r_nxt     = AW'(x_rd);
          sa_addr   = AW'(x_rd - BW'(1));
          state_nxt = salb_pkg::S_K_O;
        end
      end

      salb_pkg::S_K_O: begin
        o_nxt     = sa_rd;
        state_nxt = salb_pkg::S_K_CMP_A;
      end

      salb_pkg::S_K_CMP_A: begin
        sum_a = (IW + 1)'(i_r) + (IW + 1)'(k_r);
        sum_b = (IW + 1)'(o_r) + (IW + 1)'(k_r);
        if (sum_a < (IW + 1)'(n_r) && sum_b < (IW + 1)'(n_r)) begin
          txt_addr  = AW'(sum_a);
          state_nxt = salb_pkg::S_K_CMP_B;
        end else begin
          state_nxt = salb_pkg::S_K_WR;
        end
      end

      salb_pkg::S_K_CMP_B: begin
        sum_b     = (IW + 1)'(o_r) + (IW + 1)'(k_r);
        t_nxt     = txt_rd;
        txt_addr  = AW'(sum_b);
        state_nxt = salb_pkg::S_K_CMP_C;
      end

      salb_pkg::S_K_CMP_C: begin
        if (txt_rd == t_r) begin
          k_nxt     = k_r + IW'(1);
          state_nxt = salb_pkg::S_K_CMP_A;
        end else begin
          state_nxt = salb_pkg::S_K_WR;
        end
      end

      salb_pkg::S_K_WR: begin
        lcp_addr  = r_r;
        lcp_we    = 1'b1;
        lcp_wd    = AW'(k_r);
        i_nxt     = i_r + IW'(1);
        state_nxt = salb_pkg::S_K_RD;
      end

      salb_pkg::S_DONE: begin
        built_nxt = 1'b1;
        blen_nxt  = n_r;
        state_nxt = salb_pkg::S_IDLE;
      end

      default: state_nxt = salb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= salb_pkg::S_IDLE;
      loaded_r    <= '0;
      ovf_r       <= 1'b0;
      built_r     <= 1'b0;
      blen_r      <= '0;
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      ovf_r       <= ovf_nxt;
      built_r     <= built_nxt;
      blen_r      <= blen_nxt;
      out_valid_r <= out_valid_nxt;
      sel_r       <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    n_r        <= n_nxt;
    j_r        <= j_nxt;
    p_r        <= p_nxt;
    lim_r      <= lim_nxt;
    acc_r      <= acc_nxt;
    k_r        <= k_nxt;
    c_r        <= c_nxt;
    cur_y0_r   <= cur_y0_nxt;
    cur_y1_r   <= cur_y1_nxt;
    prev_y0_r  <= prev_y0_nxt;
    prev_y1_r  <= prev_y1_nxt;
    cur_in_r   <= cur_in_nxt;
    prev_in_r  <= prev_in_nxt;
    yi_r       <= yi_nxt;
    cur_b_r    <= cur_b_nxt;
    r_r        <= r_nxt;
    o_r        <= o_nxt;
    t_r        <= t_nxt;
    rank_r     <= rank_nxt;
    out_data_r <= out_data_nxt;
  end

  // A finished build always matches the stored text plus the sentinel.
  a_built_len : assert property (@(posedge clk) disable iff (!rst_n)
    built_r |-> (blen_r == loaded_r + IW'(1)))
    else $error("built length does not match loaded text");

  // Never store more symbols than the capacity.
  a_capacity : assert property (@(posedge clk) disable iff (!rst_n)
    32'(loaded_r) <= MAX_LEN)
    else $error("loaded count beyond capacity");

  // A read result appears only right after the read data stage.
  a_result_src : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == salb_pkg::S_RD_D))
    else $error("result raised outside read stage");

  // The text length does not change while a build or a read is running.
  a_build_stable : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != salb_pkg::S_IDLE) |=> $stable(loaded_r))
    else $error("text length changed during build or read");

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the suffix array / LCP builder. A queue of pending
// items drives the input stream with random gaps. A behavioral copy of the
// prefix-doubling sort and the Kasai LCP pass predicts every read result. The
// output stream is checked in order against the predicted results, with
// random backpressure on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = 4096;
  localparam int TEXT_MAX   = 4095;
  localparam int ALPHA      = 256;
  localparam int RAND_ITEMS = 1150;
  localparam int CYCLE_CAP  = 8000000;

  typedef struct {
    salb_pkg::salb_op_t op;
    logic [7:0]         symbol;
    logic [11:0]        rank_index;
    bit                 hold;      // wait here until every read result is back
  } cmd_item_t;

  typedef struct {
    salb_pkg::salb_status_t status;
    logic [11:0]            suffix_start;
    logic [11:0]            common_prefix;
    logic [12:0]            text_length;
  } read_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;    // op[1:0], symbol[9:2], rank_index[21:10]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;   // status[1:0], suffix_start[13:2],
                            // common_prefix[25:14], text_length[38:26]

  cmd_item_t    pending_cmds[$];
  read_result_t read_results_due[$];
  int           fail_count;
  int unsigned  cycle_count;
  bit           calm_mode;

  // Shadow copy of the block's text and sort tables.
  int unsigned text_sym[DEPTH];
  int unsigned sorted_pos[DEPTH];
  int unsigned rank_cur[DEPTH];
  int unsigned rank_old[DEPTH];
  int unsigned lcp_len[DEPTH];
  int unsigned bucket[DEPTH];
  int unsigned text_count;
  int unsigned built_len;
  bit          text_overflow;
  bit          text_built;

  suffix_array_lcp_builder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Mostly short gaps, a few long ones; calm stretches have none at all.
  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 99) < 3) calm_mode = !calm_mode;
    if (calm_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Sort all suffixes by prefix doubling, then run Kasai for the LCP table.
  function automatic void build_suffix_table();
    int unsigned n, lim, j, p, i, k, c, a, b, r, o, t;
    bit          same;
    n = text_count + 1;
    text_sym[text_count] = 0;
    lim = ALPHA;
    j = 0;
    p = 0;
    for (i = 0; i < n; i++) begin
      rank_cur[i]   = text_sym[i];
      sorted_pos[i] = i;
    end
    while (p < n) begin
      // order suffixes by their second key
      p = 0;
      for (i = 0; i < j && i < n; i++) begin
        rank_old[p] = n - j + i;
        p++;
      end
      for (i = 0; i < n; i++) begin
        if (sorted_pos[i] >= j && p < n) begin
          rank_old[p] = sorted_pos[i] - j;
          p++;
        end
      end
      // stable counting sort on the first key
      for (i = 0; i < DEPTH; i++) bucket[i] = 0;
      for (i = 0; i < n; i++) bucket[rank_cur[i]]++;
      for (i = 1; i < lim && i < DEPTH; i++) bucket[i] += bucket[i-1];
      for (i = n; i > 0; i--) begin
        c = rank_cur[rank_old[i-1]];
        bucket[c]--;
        sorted_pos[bucket[c] % DEPTH] = rank_old[i-1];
      end
      for (i = 0; i < n; i++) begin
        t           = rank_cur[i];
        rank_cur[i] = rank_old[i];
        rank_old[i] = t;
      end
      // re-rank: equal pairs share a rank
      p = 1;
      rank_cur[sorted_pos[0]] = 0;
      for (i = 1; i < n; i++) begin
        a = sorted_pos[i-1];
        b = sorted_pos[i];
        same = rank_old[a] == rank_old[b] && a + j < n && b + j < n &&
               rank_old[a+j] == rank_old[b+j];
        if (same) begin
          rank_cur[b] = p - 1;
        end else begin
          rank_cur[b] = p;
          p++;
        end
      end
      lim = p;
      j = (j != 0) ? j * 2 : 1;
    end
    lcp_len[0] = 0;
    k = 0;
    for (i = 0; i + 1 < n; i++) begin
      r = rank_cur[i];
      if (k > 0) k--;
      if (r == 0) begin
        k = 0;
        continue;
      end
      o = sorted_pos[r-1];
      while (i + k < n && o + k < n && text_sym[i+k] == text_sym[o+k]) k++;
      lcp_len[r] = k;
    end
    built_len  = n;
    text_built = 1'b1;
  endfunction

  // Apply one accepted item to the shadow state; queue a result for reads.
  function automatic void apply_cmd(cmd_item_t it);
    read_result_t res;
    case (it.op)
      salb_pkg::OP_LOAD: begin
        if (it.symbol != 0) begin
          if (text_count >= TEXT_MAX) begin
            text_overflow = 1'b1;
          end else begin
            text_sym[text_count] = it.symbol;
            text_count++;
            text_built = 1'b0;
          end
        end
      end
      salb_pkg::OP_BUILD: begin
        build_suffix_table();
      end
      salb_pkg::OP_CLEAR: begin
        text_count    = 0;
        text_overflow = 1'b0;
        text_built    = 1'b0;
        built_len     = 0;
      end
      default: begin
        res = '{salb_pkg::ST_OK, '0, '0, '0};
        if (!text_built) begin
          res.status = salb_pkg::ST_NOT_BUILT;
        end else begin
          res.text_length = built_len[12:0];
          if (it.rank_index >= built_len) begin
            res.status = salb_pkg::ST_RANGE;
          end else begin
            res.status       = text_overflow ? salb_pkg::ST_OVERFLOW : salb_pkg::ST_OK;
            res.suffix_start = sorted_pos[it.rank_index][11:0];
            if (it.rank_index != 0) res.common_prefix = lcp_len[it.rank_index][11:0];
          end
        end
        read_results_due.insert(read_results_due.size(), res);
      end
    endcase
  endfunction

  function automatic void add_cmd(salb_pkg::salb_op_t op, int sym, int rk);
    pending_cmds.insert(pending_cmds.size(), cmd_item_t'{op, sym[7:0], rk[11:0], 1'b0});
  endfunction

  function automatic void add_hold();
    pending_cmds.insert(pending_cmds.size(),
                        cmd_item_t'{salb_pkg::OP_READ, 8'd0, 12'd0, 1'b1});
  endfunction

  // Random text of len symbols; a narrow alphabet gives long repeats.
  function automatic void add_text(int len, int top_sym);
    for (int i = 0; i < len; i++) add_cmd(salb_pkg::OP_LOAD, $urandom_range(1, top_sym), 0);
  endfunction

  // ---- input driver: one item at a time, gaps between items ----
  cmd_item_t cur_cmd;
  int        in_gap;

  always @(posedge clk) begin
    bit busy;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_gap    = 0;
    end else begin
      busy = in_tvalid;
      if (in_tvalid && in_tready) begin
        apply_cmd(cur_cmd);
        busy = 1'b0;
      end
      if (!busy) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_cmds.size() > 0) begin
          if (pending_cmds[0].hold) begin
            // hold off until the result side has drained
            if (read_results_due.size() == 0) void'(pending_cmds.pop_front());
          end else begin
            cur_cmd = pending_cmds.pop_front();
            busy    = 1'b1;
            in_gap  = pick_gap();
          end
        end
      end
      in_tvalid <= busy;
      in_tdata  <= {2'b00, cur_cmd.rank_index, cur_cmd.symbol, cur_cmd.op};
    end
  end

  // ---- result monitor: compare in order, stall at random ----
  int out_gap;

  always @(posedge clk) begin
    read_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap    = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (read_results_due.size() == 0) begin
          $error("unexpected result item, tdata %h", out_tdata);
          fail_count++;
        end else begin
          want = read_results_due.pop_front();
          if (out_tdata[1:0] != want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_tdata[1:0]);
            fail_count++;
          end
          if (out_tdata[13:2] != want.suffix_start) begin
            $error("suffix_start: expected %0d, actual %0d",
                   want.suffix_start, out_tdata[13:2]);
            fail_count++;
          end
          if (out_tdata[25:14] != want.common_prefix) begin
            $error("common_prefix: expected %0d, actual %0d",
                   want.common_prefix, out_tdata[25:14]);
            fail_count++;
          end
          if (out_tdata[38:26] != want.text_length) begin
            $error("text_length: expected %0d, actual %0d",
                   want.text_length, out_tdata[38:26]);
            fail_count++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_gap    = pick_gap();
      end
    end
  end

  // ---- watchdog ----
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int len, top_sym, reads, produced;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    rst_n         = 1'b0;
    fail_count    = 0;
    cycle_count   = 0;
    calm_mode     = 1'b0;
    text_count    = 0;
    built_len     = 0;
    text_overflow = 1'b0;
    text_built    = 1'b0;

    // directed: not built, empty text, extremes, reserved symbol, rebuild
    add_cmd(salb_pkg::OP_READ, 0, 0);
    add_cmd(salb_pkg::OP_BUILD, 0, 0);
    add_cmd(salb_pkg::OP_READ, 0, 0);
    add_cmd(salb_pkg::OP_READ, 0, 1);
    add_cmd(salb_pkg::OP_LOAD, 255, 0);
    add_cmd(salb_pkg::OP_LOAD, 1, 0);
    add_cmd(salb_pkg::OP_LOAD, 0, 0);
    add_cmd(salb_pkg::OP_BUILD, 0, 0);
    for (int r = 0; r < 4; r++) add_cmd(salb_pkg::OP_READ, 0, r);
    add_cmd(salb_pkg::OP_READ, 0, 4095);
    add_cmd(salb_pkg::OP_LOAD, 128, 0);
    add_cmd(salb_pkg::OP_READ, 0, 1);
    add_cmd(salb_pkg::OP_CLEAR, 0, 0);
    add_cmd(salb_pkg::OP_READ, 0, 0);
    for (int i = 0; i < 6; i++) add_cmd(salb_pkg::OP_LOAD, (i % 2) ? 2 : 1, 0);
    add_cmd(salb_pkg::OP_BUILD, 0, 0);
    for (int r = 0; r < 7; r++) add_cmd(salb_pkg::OP_READ, 0, r);
    add_hold();

    // random: well-formed load/build/read sequences with some noise
    produced = 0;
    while (produced < RAND_ITEMS) begin
      if ($urandom_range(0, 9) < 8) add_cmd(salb_pkg::OP_CLEAR, 0, 0);
      len     = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                            : $urandom_range(0, 24);
      top_sym = ($urandom_range(0, 2) == 0) ? 255 : $urandom_range(1, 4);
      add_text(len, top_sym);
      if ($urandom_range(0, 9) == 0) add_cmd(salb_pkg::OP_LOAD, 0, 0);
      if ($urandom_range(0, 9) != 0) add_cmd(salb_pkg::OP_BUILD, 0, 0);
      reads = $urandom_range(1, 10);
      for (int r = 0; r < reads; r++) begin
        if ($urandom_range(0, 7) == 0) begin
          add_cmd(salb_pkg::OP_READ, 0, $urandom_range(0, 4095));
        end else begin
          add_cmd(salb_pkg::OP_READ, 0, $urandom_range(0, len + 2));
        end
      end
      if ($urandom_range(0, 7) == 0) begin
        add_cmd(salb_pkg::OP_LOAD, $urandom_range(1, 255), 0);
        add_cmd(salb_pkg::OP_READ, 0, 0);
      end
      if ($urandom_range(0, 15) == 0) add_hold();
      produced += len + reads + 3;
    end

    // tail: single-symbol text after a drained stretch
    add_hold();
    add_cmd(salb_pkg::OP_CLEAR, 0, 0);
    add_cmd(salb_pkg::OP_LOAD, 7, 0);
    add_cmd(salb_pkg::OP_BUILD, 0, 0);
    add_cmd(salb_pkg::OP_READ, 0, 1);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // drain: all items sent, all results back, then settle
    wait (pending_cmds.size() == 0 && !in_tvalid && read_results_due.size() == 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && read_results_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
